// ===== rtl/core/frac_pkg.sv =====
// shared constants, codes and command/status types of the fraction reduce block
// no dependencies
package frac_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int FIELD_W       = 16;
   localparam int NUM_W         = 33;
   localparam int DEN_W         = 32;
   localparam int PROD_W        = 2 * OPERAND_WIDTH;
   localparam int SUM_W         = PROD_W + 1;
   localparam int WORK_W        = (SUM_W > NUM_W) ? SUM_W : NUM_W;
   localparam int CNT_W         = $clog2(WORK_W + 1);

   localparam int REQ_DATA_W    = 4 * FIELD_W;
   localparam int REQ_USER_W    = 2;
   localparam int RSP_PAD_W     = ((NUM_W + DEN_W + 7) / 8) * 8 - NUM_W - DEN_W;
   localparam int RSP_DATA_W    = NUM_W + DEN_W + RSP_PAD_W;
   localparam int RSP_USER_W    = 1;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } frac_op_type;

   typedef enum logic [1:0] {
      MSEL_NUM1,
      MSEL_NUM2,
      MSEL_DEN
   } frac_msel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_1,
      S_MUL_2,
      S_MUL_3,
      S_COMBINE,
      S_CHECK,
      S_TWOS,
      S_GCD,
      S_DIV,
      S_FINISH
   } frac_state_type;

   typedef struct packed {
      logic          load;
      logic          mul_en;
      frac_msel_type mul_sel;
      logic          combine;
      logic          twos_step;
      logic          gcd_step;
      logic          div_init;
      logic          div_step;
      logic          out_load;
   } frac_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic num_zero;
      logic both_even;
      logic gcd_equal;
      logic div_last;
      logic out_free;
   } frac_stat_type;

endpackage

// ===== rtl/core/frac_datapath.sv =====
// datapath: operand registers, shared multiplier, sign-magnitude add, binary gcd,
// dual restoring divider and output register; depends on frac_pkg
module frac_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [frac_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [frac_pkg::REQ_USER_W-1:0]    req_tuser,
   input  frac_pkg::frac_cmd_type             cmd,
   output frac_pkg::frac_stat_type            stat,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [frac_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [frac_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import frac_pkg::*;

   typedef struct packed {
      logic                     neg;
      logic [OPERAND_WIDTH-1:0] mag;
   } frac_sm_type;

   function automatic frac_sm_type to_sm(input logic [FIELD_W-1:0] raw);
      logic [OPERAND_WIDTH-1:0] v;
      frac_sm_type              r;
      v     = OPERAND_WIDTH'(raw);
      r.neg = v[OPERAND_WIDTH-1];
      r.mag = r.neg ? (~v + 1'b1) : v;
      return r;
   endfunction

   frac_op_type       op_ff;
   frac_sm_type       a_ff, b_ff, c_ff, d_ff;
   logic [PROD_W-1:0] t1_mag_ff, t2_mag_ff, den_mag_ff;
   logic              t1_neg_ff, t2_neg_ff, den_neg_ff;
   logic [WORK_W-1:0] num_mag_ff;
   logic              num_neg_ff;
   logic [WORK_W-1:0] u_ff, v_ff, g_ff;
   logic [CNT_W-1:0]  k_ff, cnt_ff;
   logic [WORK_W-1:0] qn_ff, qd_ff, rn_ff, rd_ff;
   logic              rsp_valid_ff;
   logic [NUM_W-1:0]  res_num_ff;
   logic [DEN_W-1:0]  res_den_ff;
   logic              status_ff;

   // multiplier operand select
   frac_sm_type       mx, my;
   logic [PROD_W-1:0] prod;
   logic              prod_neg;

   always_comb begin
      case (cmd.mul_sel)
         MSEL_NUM1: begin
            mx = a_ff;
            my = (op_ff == OP_MUL) ? c_ff : d_ff;
         end
         MSEL_NUM2: begin
            mx = b_ff;
            my = c_ff;
         end
         default: begin
            mx = b_ff;
            my = (op_ff == OP_DIV) ? c_ff : d_ff;
         end
      endcase
      prod     = PROD_W'(mx.mag) * PROD_W'(my.mag);
      prod_neg = (prod != '0) && (mx.neg ^ my.neg);
   end

   // sign-magnitude add of the two numerator terms
   logic [WORK_W-1:0] e1, e2, sum_mag;
   logic              sum_neg;

   always_comb begin
      e1 = WORK_W'(t1_mag_ff);
      e2 = WORK_W'(t2_mag_ff);
      if (t1_neg_ff == t2_neg_ff) begin
         sum_mag = e1 + e2;
         sum_neg = t1_neg_ff;
      end else if (e1 >= e2) begin
         sum_mag = e1 - e2;
         sum_neg = t1_neg_ff;
      end else begin
         sum_mag = e2 - e1;
         sum_neg = t2_neg_ff;
      end
      if (sum_mag == '0) begin
         sum_neg = 1'b0;
      end
   end

   // restoring divider trial subtracts
   logic [WORK_W:0] tn, td;
   logic            fit_n, fit_d;

   always_comb begin
      tn    = {rn_ff, qn_ff[WORK_W-1]};
      td    = {rd_ff, qd_ff[WORK_W-1]};
      fit_n = tn >= {1'b0, g_ff};
      fit_d = td >= {1'b0, g_ff};
   end

   // signed result fields
   logic [WORK_W-1:0] wn, wd;

   always_comb begin
      wn = num_neg_ff ? ('0 - qn_ff) : qn_ff;
      wd = den_neg_ff ? ('0 - qd_ff) : qd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= frac_op_type'(req_tuser);
         a_ff  <= to_sm(req_tdata[FIELD_W-1:0]);
         b_ff  <= to_sm(req_tdata[2*FIELD_W-1:FIELD_W]);
         c_ff  <= to_sm(req_tdata[3*FIELD_W-1:2*FIELD_W]);
         d_ff  <= to_sm(req_tdata[4*FIELD_W-1:3*FIELD_W]);
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MSEL_NUM1: begin
               t1_mag_ff <= prod;
               t1_neg_ff <= prod_neg;
            end
            MSEL_NUM2: begin
               if (op_ff == OP_ADD || op_ff == OP_SUB) begin
                  t2_mag_ff <= prod;
                  t2_neg_ff <= prod_neg ^ ((op_ff == OP_SUB) && (prod != '0));
               end else begin
                  t2_mag_ff <= '0;
                  t2_neg_ff <= 1'b0;
               end
            end
            default: begin
               den_mag_ff <= prod;
               den_neg_ff <= prod_neg;
            end
         endcase
      end
      if (cmd.combine) begin
         num_mag_ff <= sum_mag;
         num_neg_ff <= sum_neg;
         u_ff       <= sum_mag;
         v_ff       <= WORK_W'(den_mag_ff);
         k_ff       <= '0;
      end else if (cmd.twos_step) begin
         u_ff <= u_ff >> 1;
         v_ff <= v_ff >> 1;
         k_ff <= k_ff + 1'b1;
      end else if (cmd.gcd_step) begin
         if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (u_ff > v_ff) begin
            u_ff <= u_ff - v_ff;
         end else begin
            v_ff <= v_ff - u_ff;
         end
      end
      if (cmd.div_init) begin
         g_ff   <= u_ff << k_ff;
         qn_ff  <= num_mag_ff;
         qd_ff  <= WORK_W'(den_mag_ff);
         rn_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rn_ff  <= fit_n ? WORK_W'(tn - {1'b0, g_ff}) : tn[WORK_W-1:0];
         rd_ff  <= fit_d ? WORK_W'(td - {1'b0, g_ff}) : td[WORK_W-1:0];
         qn_ff  <= {qn_ff[WORK_W-2:0], fit_n};
         qd_ff  <= {qd_ff[WORK_W-2:0], fit_d};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.out_load) begin
         if (den_mag_ff == '0) begin
            res_num_ff <= '0;
            res_den_ff <= '0;
            status_ff  <= 1'b1;
         end else if (num_mag_ff == '0) begin
            res_num_ff <= '0;
            res_den_ff <= DEN_W'(1);
            status_ff  <= 1'b0;
         end else begin
            res_num_ff <= wn[NUM_W-1:0];
            res_den_ff <= wd[DEN_W-1:0];
            status_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat.den_zero  = (den_mag_ff == '0);
      stat.num_zero  = (num_mag_ff == '0);
      stat.both_even = !u_ff[0] && !v_ff[0];
      stat.gcd_equal = u_ff[0] && v_ff[0] && (u_ff == v_ff);
      stat.div_last  = (cnt_ff == CNT_W'(WORK_W - 1));
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, res_den_ff, res_num_ff};
   assign rsp_tuser  = status_ff;

endmodule

// ===== rtl/core/frac_ctrl.sv =====
// controller state machine sequencing multiply, add, gcd and divide steps
// depends on frac_pkg
module frac_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  frac_pkg::frac_stat_type stat,
   output frac_pkg::frac_cmd_type  cmd
);
   import frac_pkg::*;

   frac_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MSEL_NUM1;
      req_tready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MUL_1;
            end
         end
         S_MUL_1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_NUM1;
            state_in    = S_MUL_2;
         end
         S_MUL_2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_NUM2;
            state_in    = S_MUL_3;
         end
         S_MUL_3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_DEN;
            state_in    = S_COMBINE;
         end
         S_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            if (stat.den_zero || stat.num_zero) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_TWOS;
            end
         end
         S_TWOS: begin
            if (stat.both_even) begin
               cmd.twos_step = 1'b1;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (stat.gcd_equal) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/fraction_arithmetic_reduce.sv =====
// Adds, subtracts, multiplies or divides two signed 16-bit fractions and reduces the
// result to lowest terms by the gcd of the magnitudes; signs stay as computed, a zero
// numerator gives 0/1 and a zero denominator gives 0/0 with status set. One item is in
// work at a time: the products take turns on one shared multiplier, then come an add, a check,
// a binary gcd that takes one shift or subtract per cycle on the 33-bit magnitudes, then a
// restoring division of both parts at once (zero results skip gcd and divide). The
// finished result sits in an output register, so the next item is taken while it waits.
// depends on frac_pkg, frac_ctrl, frac_datapath
module fraction_arithmetic_reduce (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [frac_pkg::REQ_DATA_W-1:0] req_tdata,  // num_a, den_a, num_b, den_b
   input  logic [frac_pkg::REQ_USER_W-1:0] req_tuser,  // cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [frac_pkg::RSP_DATA_W-1:0] rsp_tdata,  // res_num, res_den, zero pad
   output logic [frac_pkg::RSP_USER_W-1:0] rsp_tuser   // status
);
   import frac_pkg::*;

   frac_cmd_type  cmd;
   frac_stat_type stat;

   frac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   frac_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // error results carry zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("error result with nonzero fields");

   // a good result never has a zero denominator
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[NUM_W+DEN_W-1:NUM_W] != '0)
      else $error("good result with zero denominator");

   // busy right after a transfer in
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a transfer");

endmodule

// ===== test/frac_checker.sv =====
`timescale 1ns / 1ps
// checker for fraction_arithmetic_reduce: watches both stream channels, predicts the reduced
// fraction of every accepted request and compares each response field by field
// depends on frac_pkg
module frac_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [frac_pkg::REQ_DATA_W-1:0] req_tdata,  // num_a, den_a, num_b, den_b
   input  logic [frac_pkg::REQ_USER_W-1:0] req_tuser,  // cmd
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [frac_pkg::RSP_DATA_W-1:0] rsp_tdata,  // res_num, res_den, zero pad
   input  logic [frac_pkg::RSP_USER_W-1:0] rsp_tuser,  // status
   output int                              fail_count,
   output int                              pending
);
   import frac_pkg::*;

   localparam int FW = FIELD_W;

   typedef struct {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             status;
   } fraction_result_type;

   fraction_result_type expected_fractions[$];
   fraction_result_type got;
   fraction_result_type want;
   int                  errors = 0;

   function automatic fraction_result_type reduce_fraction(frac_op_type op,
                                                           logic signed [FW-1:0] na,
                                                           logic signed [FW-1:0] da,
                                                           logic signed [FW-1:0] nb,
                                                           logic signed [FW-1:0] db);
      longint              top;
      longint              bottom;
      longint unsigned     x;
      longint unsigned     y;
      longint unsigned     t;
      fraction_result_type r;
      case (op)
         OP_ADD: begin
            top    = longint'(na) * longint'(db) + longint'(da) * longint'(nb);
            bottom = longint'(da) * longint'(db);
         end
         OP_SUB: begin
            top    = longint'(na) * longint'(db) - longint'(da) * longint'(nb);
            bottom = longint'(da) * longint'(db);
         end
         OP_MUL: begin
            top    = longint'(na) * longint'(nb);
            bottom = longint'(da) * longint'(db);
         end
         default: begin
            top    = longint'(na) * longint'(db);
            bottom = longint'(da) * longint'(nb);
         end
      endcase
      r.status = 1'b0;
      if (bottom == 0) begin
         // zero denominator wins over a zero numerator
         r.num    = '0;
         r.den    = '0;
         r.status = 1'b1;
      end else if (top == 0) begin
         r.num = '0;
         r.den = 1;
      end else begin
         x = (top < 0) ? longint'(-top) : top;
         y = (bottom < 0) ? longint'(-bottom) : bottom;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         top    = top / longint'(x);
         bottom = bottom / longint'(x);
         r.num  = top[NUM_W-1:0];
         r.den  = bottom[DEN_W-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_fractions.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            expected_fractions.push_back(reduce_fraction(frac_op_type'(req_tuser),
               req_tdata[FW-1:0], req_tdata[2*FW-1:FW],
               req_tdata[3*FW-1:2*FW], req_tdata[4*FW-1:3*FW]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.num    = rsp_tdata[NUM_W-1:0];
            got.den    = rsp_tdata[NUM_W+DEN_W-1:NUM_W];
            got.status = rsp_tuser[0];
            if (expected_fractions.size() == 0) begin
               errors++;
               $display("%0t unexpected response num %h den %h status %b",
                        $time, got.num, got.den, got.status);
            end else begin
               want = expected_fractions.pop_front();
               if (got.num !== want.num) begin
                  errors++;
                  $display("%0t res_num mismatch: expected %h actual %h",
                           $time, want.num, got.num);
               end
               if (got.den !== want.den) begin
                  errors++;
                  $display("%0t res_den mismatch: expected %h actual %h",
                           $time, want.den, got.den);
               end
               if (got.status !== want.status) begin
                  errors++;
                  $display("%0t status mismatch: expected %b actual %b",
                           $time, want.status, got.status);
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= expected_fractions.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench top for fraction_arithmetic_reduce: directed corner requests, then random ones
// with random gaps and stalls on both channels; frac_checker predicts and compares
// depends on frac_pkg, frac_checker and the block under test
module tb;
   import frac_pkg::*;

   localparam int FW             = FIELD_W;
   localparam int RANDOM_ITEMS   = 1630;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 300;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // num_a, den_a, num_b, den_b
   logic [REQ_USER_W-1:0] req_tuser  = '0;  // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // res_num, res_den, zero pad
   logic [RSP_USER_W-1:0] rsp_tuser;        // status

   int fail_count;
   int pending;
   int idle_cycles = 0;
   bit no_idle     = 1'b0;

   fraction_arithmetic_reduce u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   frac_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // starts and ends at a falling edge; hold waits until every response is back
   task automatic send_fraction(frac_op_type op, logic [FW-1:0] na, logic [FW-1:0] da,
                                logic [FW-1:0] nb, logic [FW-1:0] db, bit hold);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0 || hold) req_tvalid <= 1'b0;
      if (hold) begin
         @(negedge clock);
         while (pending != 0) @(negedge clock);
      end
      repeat (gap) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {db, nb, da, na};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [FW-1:0] pick_operand();
      logic [FW-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = FW'($urandom());
         4, 5, 6:    v = FW'($urandom_range(0, 40) - 20);
         7: begin
            case ($urandom_range(0, 4))
               0:       v = 16'h8000;
               1:       v = 16'h7fff;
               2:       v = 16'hffff;
               3:       v = 16'h0001;
               default: v = 16'h0000;
            endcase
         end
         8: begin
            v = 16'h1 << $urandom_range(0, 14);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: v = FW'(($urandom_range(0, 500) - 250) * 60);
      endcase
      return v;
   endfunction

   // response side stalls
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_fraction(OP_ADD, 1, 2, 1, 2, 0);
      send_fraction(OP_SUB, 1, 2, 1, 2, 0);
      send_fraction(OP_ADD, 0, 1, 0, 5, 0);
      send_fraction(OP_MUL, 3, 0, 1, 1, 0);
      send_fraction(OP_DIV, 1, 2, 0, 3, 0);
      send_fraction(OP_MUL, 0, 0, 0, 0, 0);
      send_fraction(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
      send_fraction(OP_SUB, 16'h8000, 1, 16'h7fff, 16'h8000, 0);
      send_fraction(OP_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
      send_fraction(OP_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
      send_fraction(OP_MUL, -1, 1, 1, -1, 0);
      send_fraction(OP_DIV, 6, 4, 9, 2, 0);
      send_fraction(OP_ADD, 1, 3, 1, 6, 0);
      send_fraction(OP_SUB, -5, 7, 5, -7, 0);
      send_fraction(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
      send_fraction(OP_ADD, 16'h7fff, 1, 16'h7fff, 1, 0);
      send_fraction(OP_DIV, 0, 5, 0, 7, 0);
      send_fraction(OP_MUL, 1, 16'h8000, 16'h8000, 1, 0);
      send_fraction(OP_ADD, -1, -1, -1, -1, 0);
      send_fraction(OP_SUB, 12345, -6789, -2222, 31111, 0);
      send_fraction(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
      send_fraction(OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         no_idle = ((i % 400) >= 340);
         send_fraction(frac_op_type'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                       pick_operand(), pick_operand(), (i % 250) == 0);
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== fraction_arithmetic_reduce.f =====
rtl/core/frac_pkg.sv
rtl/core/frac_datapath.sv
rtl/core/frac_ctrl.sv
rtl/core/fraction_arithmetic_reduce.sv
test/frac_checker.sv
test/tb.sv
